/* design/mbd_pkg.sv */
// ----------------------------------------------------------------------------
// Mass dissimilarity package
// Shared constants, request codes and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mbd_pkg;

  // Default sizes of the stored training table.
  localparam int DEF_MAX_INSTANCES = 1024;
  localparam int DEF_MAX_FEATURES  = 16;

  // Fixed field widths.
  localparam int REQ_W    = 2;
  localparam int IDX_W    = 10;
  localparam int FIDX_W   = 4;
  localparam int VAL_W    = 32;
  localparam int OUT_W    = 27;
  localparam int NI_W     = 11;
  localparam int NF_W     = 5;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W    = 48;
  localparam int LCNT_W   = 11;
  localparam int FRAC_SH  = 48;

  // Reset values of the configuration registers.
  localparam logic [NI_W-1:0] NI_RESET = NI_W'(1024);
  localparam logic [NF_W-1:0] NF_RESET = NF_W'(16);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TRAIN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LEAF  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_INSTANCES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES  = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // An item is taken this cycle.
    logic leaf_rd;    // Read the leaf row from the table.
    logic setup;      // Form the per-dimension bounds, clear counts.
    logic scan;       // Scan all stored rows.
    logic sq_start;   // Clear the square accumulator.
    logic sq;         // Accumulate squared counts.
    logic sqrt_start; // Load the square root unit.
    logic sqrt;       // Run the square root unit.
    logic div_start;  // Load the divider.
    logic div_avg;    // Divider operands: average instead of leaf term.
    logic div;        // Run the divider.
    logic accum;      // Add the leaf term to the running sum.
    logic emit;       // Present the average.
  } mbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic sq_done;
    logic sqrt_done;
    logic div_done;
    logic last;
  } mbd_stat_t;

endpackage

/* design/mbd_ctrl.sv */
// ----------------------------------------------------------------------------
// Mass dissimilarity controller
// Sequences a leaf item through read, scan, square sum, square root,
// division and accumulation, and the final averaging division.
// ----------------------------------------------------------------------------
module mbd_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [1:0]               req_type,
  input  mbd_pkg::mbd_stat_t       stat,
  output mbd_pkg::mbd_cmd_t        cmd,
  output logic                     busy
);
  import mbd_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LEAF_RD  = 4'd1;
  localparam logic [3:0] ST_SETUP    = 4'd2;
  localparam logic [3:0] ST_SCAN     = 4'd3;
  localparam logic [3:0] ST_SQ       = 4'd4;
  localparam logic [3:0] ST_SQRT     = 4'd5;
  localparam logic [3:0] ST_DIV_LEAF = 4'd6;
  localparam logic [3:0] ST_ACC      = 4'd7;
  localparam logic [3:0] ST_DIV_AVG  = 4'd8;
  localparam logic [3:0] ST_EMIT     = 4'd9;

  logic [3:0] state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && req_type == REQ_LEAF) begin
          state_nxt = ST_LEAF_RD;
        end
      end
      ST_LEAF_RD: begin
        cmd.leaf_rd = 1'b1;
        state_nxt   = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          cmd.sq_start = 1'b1;
          state_nxt    = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        if (stat.sq_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt = 1'b1;
        if (stat.sqrt_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_LEAF;
        end
      end
      ST_DIV_LEAF: begin
        cmd.div = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        if (stat.last) begin
          cmd.div_start = 1'b1;
          cmd.div_avg   = 1'b1;
          state_nxt     = ST_DIV_AVG;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV_AVG: begin
        cmd.div = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* design/mbd_datapath.sv */
// ----------------------------------------------------------------------------
// Mass dissimilarity datapath
// Training table memory, query vector, per-dimension counting lanes, square
// accumulator, bit-serial square root and a shared restoring divider.
// ----------------------------------------------------------------------------
module mbd_datapath #(
  parameter int MAX_INSTANCES = mbd_pkg::DEF_MAX_INSTANCES,
  parameter int MAX_FEATURES  = mbd_pkg::DEF_MAX_FEATURES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbd_pkg::mbd_cmd_t             cmd,
  output mbd_pkg::mbd_stat_t            stat,
  input  logic [mbd_pkg::REQ_W-1:0]     in_req_type,
  input  logic [mbd_pkg::IDX_W-1:0]     in_instance_index,
  input  logic [mbd_pkg::FIDX_W-1:0]    in_feature_index,
  input  logic signed [mbd_pkg::VAL_W-1:0] in_feature_value,
  input  logic                          in_last_leaf,
  input  logic                          cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output logic [mbd_pkg::OUT_W-1:0]     out_dissimilarity
);
  import mbd_pkg::*;

  // Derived widths.
  localparam int AW     = $clog2(MAX_INSTANCES);
  localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW     = $clog2(MAX_INSTANCES + 1);
  localparam int FCW    = $clog2(MAX_FEATURES + 1);
  localparam int SQW    = 2 * CW;
  localparam int SW_RAW = SQW + FCW;
  localparam int SW     = SW_RAW + (SW_RAW % 2);
  localparam int XW     = SW + FRAC_SH;
  localparam int RW     = XW / 2;
  localparam int RIW    = $clog2(RW + 1);
  localparam int DVW    = (RW > SUM_W) ? RW : SUM_W;
  localparam int DIW    = $clog2(DVW + 1);
  localparam int DVS    = (CW > LCNT_W) ? CW : LCNT_W;
  localparam int KW     = $clog2(MAX_FEATURES + 2);

  localparam logic [SUM_W-1:0]  SUM_MAX = '1;
  localparam logic [LCNT_W-1:0] CNT_MAX = '1;
  localparam logic [OUT_W-1:0]  OUT_MAX = '1;

  // Configuration registers.
  logic [NI_W-1:0] num_inst_r;
  logic [NF_W-1:0] num_feat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_inst_r <= NI_RESET;
      num_feat_r <= NF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_INSTANCES: num_inst_r <= cfg_wdata[NI_W-1:0];
        CFG_NUM_FEATURES:  num_feat_r <= cfg_wdata[NF_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row and dimension counts, saturated into range.
  logic [CW-1:0]  n_eff;
  logic [FCW-1:0] f_eff;

  always_comb begin
    if (num_inst_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(num_inst_r) > MAX_INSTANCES) begin
      n_eff = CW'(MAX_INSTANCES);
    end else begin
      n_eff = CW'(num_inst_r);
    end
    if (num_feat_r == '0) begin
      f_eff = FCW'(1);
    end else if (32'(num_feat_r) > MAX_FEATURES) begin
      f_eff = FCW'(MAX_FEATURES);
    end else begin
      f_eff = FCW'(num_feat_r);
    end
  end

  // Decode of the incoming item.
  logic          row_in_ok, dim_in_ok;
  logic [AW-1:0] wr_row;
  logic [FW-1:0] wr_dim;
  logic [31:0]   row_ext, dim_ext;

  always_comb begin
    row_ext   = 32'(in_instance_index);
    dim_ext   = 32'(in_feature_index);
    row_in_ok = (row_ext < 32'(MAX_INSTANCES));
    dim_in_ok = (dim_ext < 32'(MAX_FEATURES));
    wr_row    = row_ext[AW-1:0];
    wr_dim    = dim_ext[FW-1:0];
  end

  // Leaf item latch.
  logic [AW-1:0] leaf_row_r;
  logic          leaf_ok_r;
  logic          last_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_req_type == REQ_LEAF) begin
      leaf_row_r <= wr_row;
      leaf_ok_r  <= row_in_ok;
      last_r     <= in_last_leaf;
    end
  end

  // Training table: one row of all dimensions per address.
  logic [MAX_FEATURES-1:0][VAL_W-1:0] mem [MAX_INSTANCES];
  logic [MAX_FEATURES-1:0][VAL_W-1:0] rd_row_r;
  logic [AW-1:0]                      rd_addr;
  logic [CW-1:0]                      j_r;

  assign rd_addr = cmd.leaf_rd ? leaf_row_r : j_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept && in_req_type == REQ_TRAIN && row_in_ok && dim_in_ok) begin
      mem[wr_row][wr_dim] <= in_feature_value;
    end
    rd_row_r <= mem[rd_addr];
  end

  // Query vector.
  logic [VAL_W-1:0] qv_r [MAX_FEATURES];

  always_ff @(posedge clk) begin
    if (cmd.accept && in_req_type == REQ_QUERY && dim_in_ok) begin
      qv_r[wr_dim] <= in_feature_value;
    end
  end

  // Scan address counter and read-valid flag.
  logic issue;
  logic vld_r;

  assign issue = cmd.scan && (j_r < n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= issue;
    end
    if (cmd.setup) begin
      j_r <= '0;
    end else if (issue) begin
      j_r <= j_r + CW'(1);
    end
  end

  assign stat.scan_done = (j_r == n_eff) && !vld_r;

  // Counting lanes, one per dimension.
  logic [VAL_W-1:0] lo_r  [MAX_FEATURES];
  logic [VAL_W-1:0] hi_r  [MAX_FEATURES];
  logic [CW-1:0]    cnt_r [MAX_FEATURES];
  logic             k_shift;
  logic [KW-1:0]    k_r;

  assign k_shift = cmd.sq && (k_r < KW'(MAX_FEATURES));

  always_ff @(posedge clk) begin
    for (int d = 0; d < MAX_FEATURES; d++) begin
      logic [VAL_W-1:0] lv, v;
      lv = leaf_ok_r ? rd_row_r[d] : '0;
      v  = rd_row_r[d];
      if (cmd.setup) begin
        if ($signed(lv) <= $signed(qv_r[d])) begin
          lo_r[d] <= lv;
          hi_r[d] <= qv_r[d];
        end else begin
          lo_r[d] <= qv_r[d];
          hi_r[d] <= lv;
        end
        cnt_r[d] <= '0;
      end else if (vld_r) begin
        if ((d < int'(f_eff)) && ($signed(lo_r[d]) <= $signed(v)) &&
            ($signed(v) <= $signed(hi_r[d]))) begin
          cnt_r[d] <= cnt_r[d] + CW'(1);
        end
      end else if (k_shift) begin
        // Counts move toward lane zero, one per cycle, for squaring.
        if (d == MAX_FEATURES - 1) begin
          cnt_r[d] <= '0;
        end else begin
          cnt_r[d] <= cnt_r[d + 1];
        end
      end
    end
  end

  // Square accumulator: multiply, register, then add.
  logic [SQW-1:0] sq_r;
  logic           sqv_r;
  logic [SW-1:0]  s_r;

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      k_r   <= '0;
      sqv_r <= 1'b0;
      s_r   <= '0;
    end else if (cmd.sq) begin
      k_r   <= k_r + KW'(1);
      sqv_r <= k_shift;
      if (k_shift) begin
        sq_r <= SQW'(cnt_r[0]) * SQW'(cnt_r[0]);
      end
      if (sqv_r) begin
        s_r <= s_r + SW'(sq_r);
      end
    end
  end

  assign stat.sq_done = (k_r == KW'(MAX_FEATURES + 1));

  // Square root of s * 2^48, two radicand bits per cycle.
  logic [XW-1:0]  rad_r;
  logic [RW-1:0]  root_r;
  logic [RW+1:0]  rem_r;
  logic [RIW-1:0] ri_r;
  logic [RW+1:0]  rem2, trial;

  always_comb begin
    rem2  = {rem_r[RW-1:0], rad_r[XW-1:XW-2]};
    trial = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad_r  <= {s_r, {FRAC_SH{1'b0}}};
      root_r <= '0;
      rem_r  <= '0;
      ri_r   <= '0;
    end else if (cmd.sqrt && ri_r != RIW'(RW)) begin
      rad_r <= {rad_r[XW-3:0], 2'b00};
      ri_r  <= ri_r + RIW'(1);
      if (rem2 >= trial) begin
        rem_r  <= rem2 - trial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem2;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign stat.sqrt_done = (ri_r == RIW'(RW));

  // Running sum and leaf count with saturation.
  logic [SUM_W-1:0]  lsum_r, lsum_nxt;
  logic [LCNT_W-1:0] lcnt_r, lcnt_nxt;
  logic [DVW-1:0]    dq_r;
  logic [DVW:0]      wide_sum;

  always_comb begin
    wide_sum = (DVW + 1)'(lsum_r) + (DVW + 1)'(dq_r);
    lsum_nxt = (wide_sum > (DVW + 1)'(SUM_MAX)) ? SUM_MAX : wide_sum[SUM_W-1:0];
    lcnt_nxt = (lcnt_r == CNT_MAX) ? lcnt_r : lcnt_r + LCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsum_r <= '0;
      lcnt_r <= '0;
    end else if (cmd.emit) begin
      lsum_r <= '0;
      lcnt_r <= '0;
    end else if (cmd.accum) begin
      lsum_r <= lsum_nxt;
      lcnt_r <= lcnt_nxt;
    end
  end

  // Shared restoring divider, one quotient bit per cycle.
  logic [DVS-1:0] dvs_r;
  logic [DVS-1:0] drem_r;
  logic [DIW-1:0] di_r;
  logic [DVS:0]   drem2;

  assign drem2 = {drem_r, dq_r[DVW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      drem_r <= '0;
      di_r   <= '0;
      if (cmd.div_avg) begin
        dq_r  <= DVW'(lsum_nxt);
        dvs_r <= DVS'(lcnt_nxt);
      end else begin
        dq_r  <= DVW'(root_r);
        dvs_r <= DVS'(n_eff);
      end
    end else if (cmd.div && di_r != DIW'(DVW)) begin
      di_r <= di_r + DIW'(1);
      if (drem2 >= {1'b0, dvs_r}) begin
        drem_r <= DVS'(drem2 - {1'b0, dvs_r});
        dq_r   <= {dq_r[DVW-2:0], 1'b1};
      end else begin
        drem_r <= drem2[DVS-1:0];
        dq_r   <= {dq_r[DVW-2:0], 1'b0};
      end
    end
  end

  assign stat.div_done = (di_r == DIW'(DVW));
  assign stat.last     = last_r;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_dissimilarity <= (dq_r > DVW'(OUT_MAX)) ? OUT_MAX : dq_r[OUT_W-1:0];
    end
  end

endmodule

/* design/mass_based_dissimilarity_unit.sv */
// ----------------------------------------------------------------------------
// Mass-based dissimilarity unit
// Stores a training table and a query vector, then averages the mass-based
// dissimilarity of a query against a list of leaf instances (Q3.24).
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  -------   ----------------   ---------------------------------------------
//  in_       start / busy       req_type, instance_index, feature_index,
//                               feature_value, last_leaf
//  out_      out_valid strobe   dissimilarity
//  cfg_      cfg_we             cfg_index, cfg_wdata
//
//  Store items (training or query value) never raise busy.
//  A leaf item keeps busy high over the scan of N rows (N is num_instances),
//  square sum, square root and division: the scan reads one row of all
//  dimensions per cycle from the single memory port; square root and
//  division run one bit a cycle. The last leaf adds an averaging division
//  and an emit state; the result strobe follows in the next cycle.
//  Synchronous active-low reset clears control state; the table is not cleared.
//  The result is shown for one cycle and cannot be held off.
module mass_based_dissimilarity_unit #(
  parameter int MAX_INSTANCES = mbd_pkg::DEF_MAX_INSTANCES,
  parameter int MAX_FEATURES  = mbd_pkg::DEF_MAX_FEATURES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [mbd_pkg::REQ_W-1:0]        in_req_type,
  input  logic [mbd_pkg::IDX_W-1:0]        in_instance_index,
  input  logic [mbd_pkg::FIDX_W-1:0]       in_feature_index,
  input  logic signed [mbd_pkg::VAL_W-1:0] in_feature_value,
  input  logic                             in_last_leaf,
  output logic                             out_valid,
  output logic [mbd_pkg::OUT_W-1:0]        out_dissimilarity,
  input  logic                             cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]        cfg_wdata
);
  import mbd_pkg::*;

  mbd_cmd_t  cmd;
  mbd_stat_t stat;

  // Sequencer.
  mbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Storage and arithmetic.
  mbd_datapath #(
    .MAX_INSTANCES (MAX_INSTANCES),
    .MAX_FEATURES  (MAX_FEATURES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_instance_index (in_instance_index),
    .in_feature_index  (in_feature_index),
    .in_feature_value  (in_feature_value),
    .in_last_leaf      (in_last_leaf),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_dissimilarity (out_dissimilarity)
  );

endmodule
